// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the bencode parser RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge.
`define BSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define BSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bsp_pkg.sv =====
// Package for the bencode stream parser: types, codes, byte constants.
// No dependencies; imported by the top level, bsp_nest_stack and bsp_decoder.
`default_nettype none

package bsp_pkg;

  localparam int MAX_NEST  = 16;
  localparam int DEPTH_W   = $clog2(MAX_NEST + 1);
  localparam int STK_DEPTH = (MAX_NEST > 1) ? MAX_NEST - 1 : 1;
  localparam int STK_IDX_W = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;

  typedef logic [DEPTH_W-1:0] depth_t;

  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [63:0] INT_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT_NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] STR_LEN_MAX   = 64'h0000_0000_7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_LIST     = 2'd1,
    KIND_DICT_KEY = 2'd2,
    KIND_DICT_VAL = 2'd3
  } kind_t;

  typedef enum logic [6:0] {
    PH_EXPECT     = 7'b0000001,
    PH_INT_SIGN   = 7'b0000010,
    PH_INT_DIGITS = 7'b0000100,
    PH_STR_LEN    = 7'b0001000,
    PH_STR_BODY   = 7'b0010000,
    PH_DONE       = 7'b0100000,
    PH_ERROR      = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DICT_OPEN = 3'd1,
    EV_LIST_OPEN = 3'd2,
    EV_CLOSE     = 3'd3,
    EV_INT_DONE  = 3'd4,
    EV_STR_LEN   = 3'd5,
    EV_STR_BYTE  = 3'd6,
    EV_ERROR     = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    ERR_OK             = 3'd0,
    ERR_ILLEGAL        = 3'd1,
    ERR_EARLY_END      = 3'd2,
    ERR_BAD_NUMBER     = 3'd3,
    ERR_KEY_NOT_STRING = 3'd4,
    ERR_MISSING_VALUE  = 3'd5,
    ERR_TOO_DEEP       = 3'd6
  } err_t;

  // Stack command from the decoder; toggle flips key/value expectation
  // of the top entry, after the pop if there is one.
  typedef struct packed {
    logic  push;
    logic  pop;
    logic  toggle;
    kind_t push_kind;
  } stack_op_t;

  typedef struct packed {
    event_t      ev;
    logic [63:0] value;
    logic [4:0]  nest;
    logic        is_key;
    err_t        err;
    logic        complete;
  } result_t;

  function automatic kind_t toggle_kind(input kind_t k);
    kind_t r;
    unique case (k)
      KIND_DICT_KEY: r = KIND_DICT_VAL;
      KIND_DICT_VAL: r = KIND_DICT_KEY;
      default:       r = k;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bencode_stream_parser.sv =====
// Top level of the bencode stream parser: input register, decoder, result register.
// Depends on bsp_pkg, bsp_decoder and assert_macros.svh.
//
//   channel   | valid       | stall        | payload
//   ----------+-------------+--------------+-------------------------------------------
//   byte in   | byte_valid  | byte_stall   | in_byte, end_of_data
//   event out | event_valid | event_stall  | event_res, value, nest_level, is_key,
//             |             |              | error_code, complete
//
// One item in, one event out; a new item may be taken every cycle.
// The item is captured in the input register, decoded against the parser state
// and written to the result register once that register is free.
// All per-byte work is one decimal multiply-accumulate (shift-add, 68-bit compare)
// plus a stack top update, all combinational between the decoder state registers.
// Reset clears control state only; there is no clearing pass, the stack entries
// are always written before they are read.
// A stalled result holds; the input register still takes one more item meanwhile.
`default_nettype none
`include "assert_macros.svh"

module bencode_stream_parser
  import bsp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire logic [7:0]         in_byte,
  input  wire logic               end_of_data,

  output logic                    event_valid,
  input  wire logic               event_stall,
  output logic [2:0]              event_res,
  output logic signed [63:0]      value,
  output logic [4:0]              nest_level,
  output logic                    is_key,
  output logic [2:0]              error_code,
  output logic                    complete
);

  // input register
  logic       in_full;
  logic [7:0] in_data;
  logic       in_last;

  // result register
  result_t    res_d;
  result_t    res_q;

  logic       res_free;
  logic       advance;
  logic       take;

  assign res_free   = !event_valid || !event_stall;
  assign advance    = in_full && res_free;
  assign byte_stall = in_full && !res_free;
  assign take       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_data <= in_byte;
      in_last <= end_of_data;
    end
  end

  bsp_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_byte     (in_data),
    .end_of_data (in_last),
    .result      (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign event_res  = res_q.ev;
  assign value      = $signed(res_q.value);
  assign nest_level = res_q.nest;
  assign is_key     = res_q.is_key;
  assign error_code = res_q.err;
  assign complete   = res_q.complete;

  `BSP_ASSERT_IMPL(a_err_code, event_valid && (event_res == EV_ERROR), error_code != ERR_OK, "error event without code")
  `BSP_ASSERT_IMPL(a_ok_code, event_valid && (event_res != EV_ERROR), error_code == ERR_OK, "code on a non-error event")
  `BSP_ASSERT_IMPL(a_complete_ok, event_valid && complete, event_res != EV_ERROR, "complete on an error event")

endmodule

`default_nettype wire

// ===== hw/rtl/bsp_digit_accum.sv =====
// Decimal accumulate step: accum * 10 + digit, with a range check.
// Depends on nothing; uses neither the package nor the assertion macros.
`default_nettype none

module bsp_digit_accum (
  input  wire logic [63:0] accum,
  input  wire logic [3:0]  digit,
  input  wire logic [63:0] limit,
  output logic      [63:0] accum_next,
  output logic             overflow
);

  logic [67:0] wide;

  // accum*10 = accum*8 + accum*2; a > (L-d)/10 is the same as 10a+d > L
  assign wide = ({4'b0, accum} << 3) + ({4'b0, accum} << 1) + {64'b0, digit};
  assign accum_next = wide[63:0];
  assign overflow   = wide > {4'b0, limit};

endmodule

`default_nettype wire

// ===== hw/rtl/bsp_nest_stack.sv =====
// Stack of open containers: top entry in a register, the rest in a small array.
// Depends on bsp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsp_nest_stack
  import bsp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      commit,
  input  wire stack_op_t op,
  input  wire logic      clear,
  output depth_t         depth,
  output kind_t          top,
  output depth_t         depth_next,
  output kind_t          top_next
);

  kind_t  under [STK_DEPTH];
  depth_t depth_m1;
  depth_t depth_m2;
  kind_t  under_rd;

  assign depth_m1 = depth - depth_t'(1);
  assign depth_m2 = depth - depth_t'(2);
  assign under_rd = under[depth_m2[STK_IDX_W-1:0]];

  always_comb begin
    depth_next = depth;
    top_next   = top;
    if (op.push) begin
      depth_next = depth + depth_t'(1);
      top_next   = op.push_kind;
    end else if (op.pop) begin
      depth_next = depth_m1;
      top_next   = (depth >= depth_t'(2)) ? under_rd : KIND_NONE;
      if (op.toggle) begin
        top_next = toggle_kind(top_next);
      end
    end else if (op.toggle) begin
      top_next = toggle_kind(top);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      top   <= KIND_NONE;
    end else if (commit) begin
      if (clear) begin
        depth <= '0;
        top   <= KIND_NONE;
      end else begin
        depth <= depth_next;
        top   <= top_next;
      end
    end
  end

  // old top sinks into the array on a push
  always_ff @(posedge clk) begin
    if (commit && op.push && (depth != '0)) begin
      under[depth_m1[STK_IDX_W-1:0]] <= top;
    end
  end

  `BSP_ASSERT(a_depth_bound, depth <= depth_t'(MAX_NEST), "nesting depth beyond MAX_NEST")
  `BSP_ASSERT_IMPL(a_empty_top, depth == '0, top == KIND_NONE, "empty stack with a top kind")

endmodule

`default_nettype wire

// ===== hw/rtl/bsp_decoder.sv =====
// Token decoder: phase, number accumulator and string counter per byte.
// Depends on bsp_pkg, bsp_digit_accum, bsp_nest_stack, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsp_decoder
  import bsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_data,
  output result_t         result
);

  phase_t      phase, phase_next;
  logic [63:0] accum, accum_next;
  logic        negative, negative_next;
  logic        digit_seen, digit_seen_next;
  logic [30:0] remaining, remaining_next;
  logic        key_flag, key_flag_next;

  stack_op_t   op;
  logic        clear;
  depth_t      depth, depth_next;
  kind_t       top, top_next;

  logic        is_digit;
  logic [63:0] limit;
  logic [63:0] acc_step;
  logic        acc_ovf;

  event_t      ev;
  err_t        err;
  logic [63:0] val;
  logic        key;
  logic        done;
  depth_t      nest_depth;

  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign limit    = (phase == PH_STR_LEN) ? STR_LEN_MAX :
                    (negative ? INT_NEG_LIMIT : INT_POS_LIMIT);

  bsp_digit_accum u_accum (
    .accum      (accum),
    .digit      (in_byte[3:0]),
    .limit      (limit),
    .accum_next (acc_step),
    .overflow   (acc_ovf)
  );

  bsp_nest_stack u_stack (
    .clk        (clk),
    .rst        (rst),
    .commit     (advance),
    .op         (op),
    .clear      (clear),
    .depth      (depth),
    .top        (top),
    .depth_next (depth_next),
    .top_next   (top_next)
  );

  always_comb begin
    phase_next      = phase;
    accum_next      = accum;
    negative_next   = negative;
    digit_seen_next = digit_seen;
    remaining_next  = remaining;
    key_flag_next   = key_flag;
    op              = '{push: 1'b0, pop: 1'b0, toggle: 1'b0, push_kind: KIND_NONE};
    clear           = 1'b0;
    ev              = EV_NONE;
    err             = ERR_OK;
    val             = '0;
    key             = 1'b0;
    done            = 1'b0;

    unique case (phase)
      PH_EXPECT: begin
        if (in_byte == CH_E) begin
          if (depth == '0) begin
            err = ERR_ILLEGAL;
          end else if (top == KIND_DICT_VAL) begin
            err = ERR_MISSING_VALUE;
          end else begin
            op.pop = 1'b1;
            ev     = EV_CLOSE;
            if (depth == depth_t'(1)) begin
              phase_next = PH_DONE;
              done       = 1'b1;
            end else begin
              op.toggle = 1'b1;
            end
          end
        end else if ((in_byte == CH_D) || (in_byte == CH_L) || (in_byte == CH_I)) begin
          if (top == KIND_DICT_KEY) begin
            err = ERR_KEY_NOT_STRING;
          end else if (in_byte == CH_I) begin
            accum_next      = '0;
            negative_next   = 1'b0;
            digit_seen_next = 1'b0;
            phase_next      = PH_INT_SIGN;
          end else if (depth >= depth_t'(MAX_NEST)) begin
            err = ERR_TOO_DEEP;
          end else begin
            op.push      = 1'b1;
            op.push_kind = (in_byte == CH_D) ? KIND_DICT_KEY : KIND_LIST;
            ev           = (in_byte == CH_D) ? EV_DICT_OPEN : EV_LIST_OPEN;
          end
        end else if (is_digit) begin
          accum_next      = {60'b0, in_byte[3:0]};
          digit_seen_next = 1'b1;
          key_flag_next   = (top == KIND_DICT_KEY);
          phase_next      = PH_STR_LEN;
        end else begin
          err = ERR_ILLEGAL;
        end
      end

      PH_INT_SIGN, PH_INT_DIGITS: begin
        if ((phase == PH_INT_SIGN) && ((in_byte == CH_MINUS) || (in_byte == CH_PLUS))) begin
          negative_next = (in_byte == CH_MINUS);
          phase_next    = PH_INT_DIGITS;
        end else if (is_digit) begin
          if (acc_ovf) begin
            err = ERR_BAD_NUMBER;
          end else begin
            accum_next      = acc_step;
            digit_seen_next = 1'b1;
            phase_next      = PH_INT_DIGITS;
          end
        end else if ((in_byte == CH_E) && digit_seen) begin
          ev  = EV_INT_DONE;
          val = negative ? (64'd0 - accum) : accum;
          if (depth == '0) begin
            phase_next = PH_DONE;
            done       = 1'b1;
          end else begin
            op.toggle  = 1'b1;
            phase_next = PH_EXPECT;
          end
        end else begin
          err = ERR_BAD_NUMBER;
        end
      end

      PH_STR_LEN: begin
        if (is_digit) begin
          if (acc_ovf) begin
            err = ERR_BAD_NUMBER;
          end else begin
            accum_next = acc_step;
          end
        end else if (in_byte == CH_COLON) begin
          ev             = EV_STR_LEN;
          val            = accum;
          key            = key_flag;
          remaining_next = accum[30:0];
          if (accum != '0) begin
            phase_next = PH_STR_BODY;
          end else if (depth == '0) begin
            phase_next = PH_DONE;
            done       = 1'b1;
          end else begin
            op.toggle  = 1'b1;
            phase_next = PH_EXPECT;
          end
        end else begin
          err = ERR_BAD_NUMBER;
        end
      end

      PH_STR_BODY: begin
        ev             = EV_STR_BYTE;
        val            = {56'b0, in_byte};
        key            = key_flag;
        remaining_next = remaining - 31'd1;
        if (remaining == 31'd1) begin
          if (depth == '0) begin
            phase_next = PH_DONE;
            done       = 1'b1;
          end else begin
            op.toggle  = 1'b1;
            phase_next = PH_EXPECT;
          end
        end
      end

      PH_DONE: begin
        done = 1'b1;
      end

      PH_ERROR: begin
      end

      default: begin
        err = ERR_ILLEGAL;
      end
    endcase

    // last byte: close open containers quietly if none pending, else error
    if ((err == ERR_OK) && end_of_data && (phase != PH_DONE) && (phase != PH_ERROR)
        && (phase_next != PH_DONE)) begin
      if ((phase_next != PH_EXPECT) || (depth_next == '0)) begin
        err = ERR_EARLY_END;
      end else if (top_next == KIND_DICT_VAL) begin
        err = ERR_MISSING_VALUE;
      end else begin
        clear      = 1'b1;
        phase_next = PH_DONE;
        done       = 1'b1;
      end
    end

    if (err != ERR_OK) begin
      ev         = EV_ERROR;
      val        = '0;
      key        = 1'b0;
      done       = 1'b0;
      phase_next = PH_ERROR;
    end
  end

  assign nest_depth = clear ? '0 : depth_next;

  always_comb begin
    result.ev       = ev;
    result.value    = val;
    result.nest     = 5'(nest_depth);
    result.is_key   = key;
    result.err      = err;
    result.complete = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_EXPECT;
      accum      <= '0;
      negative   <= 1'b0;
      digit_seen <= 1'b0;
      remaining  <= '0;
      key_flag   <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      accum      <= accum_next;
      negative   <= negative_next;
      digit_seen <= digit_seen_next;
      remaining  <= remaining_next;
      key_flag   <= key_flag_next;
    end
  end

  `BSP_ASSERT_NEXT(a_error_sticks, phase == PH_ERROR, phase == PH_ERROR, "left error phase")
  `BSP_ASSERT_IMPL(a_done_empty, phase == PH_DONE, depth == '0, "containers open after done")

endmodule

`default_nettype wire

// ===== tb/tb_bencode_stream_parser.sv =====
// Self-checking testbench for bencode_stream_parser: one long bencoded message with
// random content, a seed-chosen ending, random idling on both channels, scoreboard.
// Depends on bsp_pkg and the bencode_stream_parser RTL.
`timescale 1ns / 100ps

module tb_bencode_stream_parser;
  import bsp_pkg::*;

  // How the message ends; one is picked per seed, since only one reset is allowed
  typedef enum int {
    END_CLOSE,      // every container closed by 'e'
    END_OPEN,       // end flag after a value, containers closed silently
    END_KEY_EOD,    // end flag right after a key: missing value
    END_INT_EOD,    // end flag inside an integer
    END_LEN_EOD,    // end flag inside a huge string body
    END_LEN_BIG,    // string length beyond 31 bits
    END_INT_BIG,    // integer outside the signed 64-bit range
    END_INT_FORM,   // malformed integer
    END_KEY_KIND,   // container or integer where a key is due
    END_KEY_JUNK,   // other junk where a key is due
    END_NO_VALUE,   // dictionary closed after a key
    END_TOO_DEEP,   // one container too many
    END_JUNK,       // illegal byte where a value is due
    END_STRAY       // close at top level as the very first item
  } ending_t;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off, once

  logic clk;
  logic rst = 1'b1;

  logic        byte_valid  = 1'b0;
  logic        byte_stall;
  logic [7:0]  in_byte     = 8'h00;
  logic        end_of_data = 1'b0;

  logic               event_valid;
  logic               event_stall = 1'b0;
  logic [2:0]         event_res;
  logic signed [63:0] value;
  logic [4:0]         nest_level;
  logic               is_key;
  logic [2:0]         error_code;
  logic               complete;

  bencode_stream_parser u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .in_byte     (in_byte),
    .end_of_data (end_of_data),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_res   (event_res),
    .value       (value),
    .nest_level  (nest_level),
    .is_key      (is_key),
    .error_code  (error_code),
    .complete    (complete)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan: {end_of_data, byte} per item, plus the message shape tracker
  // ---------------------------------------------------------------------------
  logic [8:0] pending_bytes [$];
  kind_t      gen_stack [$];     // open containers of the message being built
  ending_t    ending;

  int bytes_total = 0;
  int bytes_taken = 0;
  int events_seen = 0;
  int failures    = 0;
  int deepest     = 0;
  int ev_tally [8];

  function automatic logic is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic int short_len();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(9, 40));
    return int'($urandom_range(0, 8));
  endfunction

  task automatic put(input logic [7:0] b, input logic eod = 1'b0);
    pending_bytes.push_back({eod, b});
  endtask

  // raise the end flag on the item last planned
  task automatic mark_last_end();
    logic [8:0] t;
    t = pending_bytes.pop_back();
    pending_bytes.push_back({1'b1, t[7:0]});
  endtask

  task automatic put_decimal(input logic [63:0] mag);
    logic [7:0]  digs [$];
    logic [63:0] m;
    logic [63:0] q;
    m = mag;
    do begin
      q = m % 10;
      digs.push_front(CH_ZERO + q[7:0]);
      m = m / 10;
    end while (m != 0);
    foreach (digs[i]) put(digs[i]);
  endtask

  task automatic gen_string(input int len);
    if ($urandom_range(0, 7) == 0) put(CH_ZERO);   // leading zero is legal
    put_decimal(len);
    put(CH_COLON);
    repeat (len) put(rand_byte());
  endtask

  task automatic gen_int();
    logic [63:0] mag;
    int form;
    form = $urandom_range(0, 9);
    mag  = {$urandom, $urandom} >> $urandom_range(1, 63);
    put(CH_I);
    case (form)
      0: put_decimal(INT_POS_LIMIT);
      1: begin
        put(CH_MINUS);
        put_decimal(INT_NEG_LIMIT);
      end
      2, 3: begin
        put(CH_MINUS);
        put_decimal(mag);
      end
      4: begin
        put(CH_PLUS);
        put_decimal(mag);
      end
      5: begin
        put(CH_ZERO);
        put(CH_ZERO);
        put_decimal(mag);
      end
      6: begin
        if ($urandom_range(0, 1) == 1) put(CH_MINUS);
        put_decimal(64'd0);
      end
      default: put_decimal(mag);
    endcase
    put(CH_E);
  endtask

  function automatic kind_t gen_top();
    if (gen_stack.size() == 0) return KIND_NONE;
    return gen_stack[gen_stack.size() - 1];
  endfunction

  task automatic set_top(input kind_t k);
    gen_stack[gen_stack.size() - 1] = k;
  endtask

  // Make room for a value: a dict awaiting a key gets one first; then the
  // dict flips back to wanting a key once this value is in.
  task automatic claim_slot();
    if (gen_top() == KIND_DICT_KEY) begin
      gen_string(short_len());
      set_top(KIND_DICT_VAL);
    end
    if (gen_top() == KIND_DICT_VAL) set_top(KIND_DICT_KEY);
  endtask

  task automatic open_nested(input kind_t k);
    claim_slot();
    put(k == KIND_LIST ? CH_L : CH_D);
    gen_stack.push_back(k);
  endtask

  task automatic close_nested();
    put(CH_E);
    void'(gen_stack.pop_back());
  endtask

  task automatic unwind(input int keep);
    while (gen_stack.size() > keep) begin
      if (gen_top() == KIND_DICT_VAL) begin
        claim_slot();
        gen_int();
      end
      close_nested();
    end
  endtask

  // One random step of well-formed content; never closes the outermost container
  task automatic grow_body();
    int lvl;
    int pick;
    lvl  = gen_stack.size();
    pick = $urandom_range(0, 19);
    if (lvl < MAX_NEST && $urandom_range(0, 299) == 0) begin
      while (gen_stack.size() < MAX_NEST) open_nested(KIND_LIST);   // dive to full depth
    end else if (gen_top() == KIND_DICT_KEY) begin
      if (lvl > 1 && pick < 3) begin
        close_nested();
      end else begin
        gen_string(short_len());
        set_top(KIND_DICT_VAL);
      end
    end else if (gen_top() == KIND_LIST && lvl > 1 && pick < (lvl > 6 ? 5 : 2)) begin
      close_nested();
    end else if (lvl < MAX_NEST && pick < (lvl > 6 ? 7 : 8)) begin
      open_nested(pick[0] ? KIND_DICT_KEY : KIND_LIST);
    end else if (pick < 15) begin
      claim_slot();
      gen_int();
    end else begin
      claim_slot();
      gen_string(short_len());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Parser predictor: own copy of the decoder state, one event per item
  // ---------------------------------------------------------------------------
  phase_t      ps_phase     = PH_EXPECT;
  logic [4:0]  ps_depth     = 5'd0;
  kind_t       ps_stack [MAX_NEST];
  logic [63:0] ps_accum     = 64'd0;
  logic        ps_neg       = 1'b0;
  logic        ps_digit     = 1'b0;
  logic [31:0] ps_remaining = 32'd0;
  logic        ps_key       = 1'b0;

  result_t awaited_events [$];

  function automatic kind_t stack_top();
    if (ps_depth == 0) return KIND_NONE;
    return ps_stack[ps_depth - 1];
  endfunction

  // A value just ended: the top-level one finishes the message, otherwise an
  // enclosing dict swaps between wanting a key and wanting a value.
  function automatic logic value_closed();
    if (ps_depth == 0) begin
      ps_phase = PH_DONE;
      return 1'b1;
    end
    if (stack_top() == KIND_DICT_KEY) ps_stack[ps_depth - 1] = KIND_DICT_VAL;
    else if (stack_top() == KIND_DICT_VAL) ps_stack[ps_depth - 1] = KIND_DICT_KEY;
    ps_phase = PH_EXPECT;
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eod);
    result_t     r;
    kind_t       k;
    event_t      ev;
    err_t        err;
    logic [63:0] val;
    logic [63:0] d;
    logic [63:0] lim;
    logic        key;
    logic        done;
    r    = '0;
    ev   = EV_NONE;
    err  = ERR_OK;
    val  = 64'd0;
    key  = 1'b0;
    done = 1'b0;
    d    = {56'd0, b - CH_ZERO};
    if (ps_phase == PH_DONE || ps_phase == PH_ERROR) begin
      // stream is over: items are swallowed; depth frozen only after an error
      r.ev       = EV_NONE;
      r.nest     = (ps_phase == PH_DONE) ? 5'd0 : ps_depth;
      r.err      = ERR_OK;
      r.complete = (ps_phase == PH_DONE);
    end else begin
      case (ps_phase)
        PH_EXPECT: begin
          k = stack_top();
          if (b == CH_E) begin
            if (ps_depth == 0) begin
              err = ERR_ILLEGAL;
            end else if (k == KIND_DICT_VAL) begin
              err = ERR_MISSING_VALUE;
            end else begin
              ps_depth = ps_depth - 1;
              ev       = EV_CLOSE;
              done     = value_closed();
            end
          end else if (b == CH_D || b == CH_L || b == CH_I) begin
            if (k == KIND_DICT_KEY) begin
              err = ERR_KEY_NOT_STRING;
            end else if (b == CH_I) begin
              ps_accum = 64'd0;
              ps_neg   = 1'b0;
              ps_digit = 1'b0;
              ps_phase = PH_INT_SIGN;
            end else if (ps_depth >= MAX_NEST) begin
              err = ERR_TOO_DEEP;
            end else begin
              ps_stack[ps_depth] = (b == CH_D) ? KIND_DICT_KEY : KIND_LIST;
              ps_depth           = ps_depth + 1;
              ev                 = (b == CH_D) ? EV_DICT_OPEN : EV_LIST_OPEN;
            end
          end else if (is_digit(b)) begin
            ps_accum = d;
            ps_digit = 1'b1;
            ps_key   = (k == KIND_DICT_KEY);
            ps_phase = PH_STR_LEN;
          end else begin
            err = ERR_ILLEGAL;
          end
        end
        PH_INT_SIGN, PH_INT_DIGITS: begin
          if (ps_phase == PH_INT_SIGN && (b == CH_MINUS || b == CH_PLUS)) begin
            ps_neg   = (b == CH_MINUS);
            ps_phase = PH_INT_DIGITS;
          end else if (is_digit(b)) begin
            lim = ps_neg ? INT_NEG_LIMIT : INT_POS_LIMIT;
            if (ps_accum > (lim - d) / 10) begin
              err = ERR_BAD_NUMBER;
            end else begin
              ps_accum = ps_accum * 10 + d;
              ps_digit = 1'b1;
              ps_phase = PH_INT_DIGITS;
            end
          end else if (b == CH_E && ps_digit) begin
            ev   = EV_INT_DONE;
            val  = ps_neg ? -ps_accum : ps_accum;
            done = value_closed();
          end else begin
            err = ERR_BAD_NUMBER;
          end
        end
        PH_STR_LEN: begin
          if (is_digit(b)) begin
            if (ps_accum > (STR_LEN_MAX - d) / 10) err = ERR_BAD_NUMBER;
            else ps_accum = ps_accum * 10 + d;
          end else if (b == CH_COLON) begin
            ev           = EV_STR_LEN;
            val          = ps_accum;
            key          = ps_key;
            ps_remaining = ps_accum[31:0];
            if (ps_remaining == 0) done = value_closed();   // empty string ends here
            else ps_phase = PH_STR_BODY;
          end else begin
            err = ERR_BAD_NUMBER;
          end
        end
        PH_STR_BODY: begin
          ev           = EV_STR_BYTE;
          val          = {56'd0, b};
          key          = ps_key;
          ps_remaining = ps_remaining - 1;
          if (ps_remaining == 0) done = value_closed();
        end
        default: err = ERR_ILLEGAL;
      endcase

      // end flag: a token in flight is an early end; open containers are shut
      // quietly unless the innermost dict still owes a value
      if (err == ERR_OK && eod && ps_phase != PH_DONE) begin
        if (ps_phase != PH_EXPECT || ps_depth == 0) begin
          err = ERR_EARLY_END;
        end else if (stack_top() == KIND_DICT_VAL) begin
          err = ERR_MISSING_VALUE;
        end else begin
          ps_depth = 5'd0;
          ps_phase = PH_DONE;
          done     = 1'b1;
        end
      end

      if (err != ERR_OK) begin
        ev       = EV_ERROR;
        val      = 64'd0;
        key      = 1'b0;
        done     = 1'b0;
        ps_phase = PH_ERROR;
      end

      r.ev       = ev;
      r.value    = val;
      r.nest     = ps_depth;
      r.is_key   = key;
      r.err      = err;
      r.complete = done;
    end
    if (int'(ps_depth) > deepest) deepest = ps_depth;
    ev_tally[r.ev]++;
    awaited_events.push_back(r);
  endfunction

  // Idling is off in every third stretch of 250 items and over the last 150
  function automatic logic idling_on();
    return (bytes_taken + 150 < bytes_total) && ((bytes_taken / 250) % 3 != 2);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: offers planned items, gaps in random bursts
  // ---------------------------------------------------------------------------
  int         send_gap = 0;
  logic [8:0] next_item;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        decode_byte(in_byte, end_of_data);
        bytes_taken++;
      end
      // load a new item only once the current one has gone; a stalled one holds
      if (!byte_valid || !byte_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && idling_on() &&
                     $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 5);   // this cycle is the first of the gap
          byte_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_item = pending_bytes.pop_front();
          byte_valid  <= 1'b1;
          in_byte     <= next_item[7:0];
          end_of_data <= next_item[8];
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Event monitor and receiver stalls
  // ---------------------------------------------------------------------------
  int      stall_left = 0;
  int      hold_left  = 0;
  logic    held_once  = 1'b0;
  result_t got;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      event_stall <= 1'b0;
    end else begin
      if (event_valid && !event_stall) begin
        got.ev       = event_t'(event_res);
        got.value    = value;
        got.nest     = nest_level;
        got.is_key   = is_key;
        got.err      = err_t'(error_code);
        got.complete = complete;
        if (awaited_events.size() == 0) begin
          $display("%0t: event with nothing expected: got ev=%0d val=%0d nest=%0d",
                   $time, got.ev, $signed(got.value), got.nest);
          failures++;
        end else begin
          want = awaited_events.pop_front();
          if (got !== want) begin
            $display({"%0t: event mismatch: expected ev=%0d val=%0d nest=%0d",
                      " key=%0b err=%0d cpl=%0b"},
                     $time, want.ev, $signed(want.value), want.nest, want.is_key,
                     want.err, want.complete);
            $display({"%0t:                   actual ev=%0d val=%0d nest=%0d",
                      " key=%0b err=%0d cpl=%0b"},
                     $time, got.ev, $signed(got.value), got.nest, got.is_key,
                     got.err, got.complete);
            failures++;
          end
        end
        events_seen++;
      end
      // one long hold-off so the parser backs up and stalls its input side
      if (hold_left > 0) begin
        hold_left--;
        event_stall <= 1'b1;
      end else if (!held_once && events_seen >= 200) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        event_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        event_stall <= 1'b1;
      end else if (idling_on() && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 5);
        event_stall <= 1'b1;
      end else begin
        event_stall <= 1'b0;
      end
    end
  end

  // Watchdog: a long spell with no handshake on either side ends the run
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (event_valid && !event_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d events still awaited",
               $time, QUIET_LIMIT, awaited_events.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Plan the message, release reset, wait for the drain, report
  // ---------------------------------------------------------------------------
  initial begin : main
    logic [7:0] b;
    int         n;
    int         tail_len;
    if ($urandom_range(0, 39) == 0) ending = END_STRAY;
    else ending = ending_t'($urandom_range(0, END_JUNK));

    if (ending == END_STRAY) begin
      put(CH_E);                  // stray close at top level, rest is ignored
      tail_len = 1500;
    end else begin
      tail_len = 40;
      // directed opening: empty key, empty list, key byte FF, signed padded int,
      // key byte 00, empty dict
      open_nested(KIND_DICT_KEY);
      put(CH_ZERO);
      put(CH_COLON);
      set_top(KIND_DICT_VAL);
      open_nested(KIND_LIST);
      close_nested();
      put_decimal(64'd1);
      put(CH_COLON);
      put(8'hFF);
      set_top(KIND_DICT_VAL);
      claim_slot();
      put(CH_I);
      put(CH_PLUS);
      put(CH_ZERO);
      put(CH_ZERO);
      put_decimal(64'd7);
      put(CH_E);
      put_decimal(64'd1);
      put(CH_COLON);
      put(8'h00);
      set_top(KIND_DICT_VAL);
      open_nested(KIND_DICT_KEY);
      close_nested();

      // random well-formed body inside the outer dict
      while (pending_bytes.size() < 1400) grow_body();

      if (ending != END_CLOSE) unwind(1);
      case (ending)
        END_CLOSE: begin
          unwind(0);
          if ($urandom_range(0, 1) == 1) mark_last_end();
        end
        END_OPEN: begin
          repeat ($urandom_range(0, 3))
            open_nested($urandom_range(0, 1) == 1 ? KIND_DICT_KEY : KIND_LIST);
          claim_slot();
          if ($urandom_range(0, 1) == 1) gen_int();
          else gen_string($urandom_range(0, 3));
          mark_last_end();
        end
        END_KEY_EOD: begin
          open_nested(KIND_DICT_KEY);
          gen_string(short_len());
          mark_last_end();
        end
        END_INT_EOD: begin
          open_nested(KIND_LIST);
          put(CH_I);
          if ($urandom_range(0, 1) == 1) put(CH_MINUS);
          repeat ($urandom_range(0, 3)) put(CH_ZERO + 8'd5);
          mark_last_end();
        end
        END_LEN_EOD: begin
          open_nested(KIND_LIST);
          put_decimal(STR_LEN_MAX);
          put(CH_COLON);
          repeat ($urandom_range(0, 3)) put(rand_byte());
          mark_last_end();
        end
        END_LEN_BIG: begin
          open_nested(KIND_LIST);
          put_decimal($urandom_range(0, 1) == 1 ? 64'd2147483648 : 64'd9999999999);
        end
        END_INT_BIG: begin
          open_nested(KIND_LIST);
          put(CH_I);
          if ($urandom_range(0, 1) == 1) begin
            put_decimal(INT_POS_LIMIT + 1);
          end else begin
            put(CH_MINUS);
            put_decimal(INT_NEG_LIMIT + 1);
          end
        end
        END_INT_FORM: begin
          open_nested(KIND_LIST);
          put(CH_I);
          case ($urandom_range(0, 4))
            0: put(CH_E);
            1: begin
              put(CH_MINUS);
              put(CH_E);
            end
            2: begin
              put(CH_PLUS);
              put(CH_MINUS);
            end
            3: begin
              put_decimal(64'd12);
              put(CH_COLON);
            end
            default: put(8'h20);
          endcase
        end
        END_KEY_KIND: begin
          open_nested(KIND_DICT_KEY);
          n = $urandom_range(0, 2);
          put(n == 0 ? CH_D : (n == 1 ? CH_L : CH_I));
        end
        END_KEY_JUNK: begin
          open_nested(KIND_DICT_KEY);
          do b = rand_byte(); while (is_digit(b) || b == CH_E);
          put(b);
        end
        END_NO_VALUE: begin
          open_nested(KIND_DICT_KEY);
          gen_string(short_len());
          put(CH_E);
        end
        END_TOO_DEEP: begin
          while (gen_stack.size() < MAX_NEST) open_nested(KIND_LIST);
          put($urandom_range(0, 1) == 1 ? CH_D : CH_L);
        end
        default: begin
          open_nested(KIND_LIST);
          do b = rand_byte();
          while (is_digit(b) || b == CH_E || b == CH_D || b == CH_L || b == CH_I);
          put(b);
        end
      endcase
    end

    // noise after the message: must all be swallowed
    repeat (tail_len) begin
      n = $urandom;
      put(n[7:0], n[8]);
    end

    bytes_total = pending_bytes.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_total) @(posedge clk);
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);   // catch any surplus event

    $display("Summary: %0d items in, message ended by %s, deepest nesting %0d",
             bytes_taken, ending.name(), deepest);
    $display("Summary: %0d events checked: %0d ints, %0d strings, %0d string bytes, %0d errors",
             events_seen, ev_tally[EV_INT_DONE], ev_tally[EV_STR_LEN],
             ev_tally[EV_STR_BYTE], ev_tally[EV_ERROR]);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
